FILE: rtl/swarq_pkg.sv
// ----------------------------------------------------------------------------
// Stop-and-wait ARQ sender package
// Shared types, codes and fixed constants of the sender and its checker.
// ----------------------------------------------------------------------------
package swarq_pkg;

  localparam int unsigned SEQ_W   = 16;
  localparam int unsigned LEN_W   = 13;
  localparam int unsigned ATT_W   = 4;
  localparam int unsigned TIMER_W = 16;

  // Longest chunk that is passed on; longer offers are clipped to it.
  localparam logic [LEN_W-1:0] MAX_CHUNK = 13'd5120;

  localparam logic [TIMER_W-1:0] TIMEOUT_RST   = 16'd100;
  localparam logic [TIMER_W-1:0] LATE_ACK_RST  = 16'd10;
  localparam logic [ATT_W-1:0]   MAX_SENDS_RST = 4'd6;

  typedef enum logic [1:0] {
    KIND_CHUNK = 2'd0,
    KIND_ACK   = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ACT_DATA  = 2'd0,
    ACT_END   = 2'd1,
    ACT_ACKED = 2'd2,
    ACT_ABORT = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WAIT = 2'd1,
    MODE_LATE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    REG_TIMEOUT   = 2'd0,
    REG_LATE_ACK  = 2'd1,
    REG_MAX_SENDS = 2'd2
  } reg_e;

  typedef struct packed {
    action_e            action;
    logic [SEQ_W-1:0]   seq;
    logic [LEN_W-1:0]   length;
    logic [ATT_W-1:0]   attempt;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [TIMER_W-1:0] timeout_ticks;
    logic [TIMER_W-1:0] late_ack_ticks;
    logic [ATT_W-1:0]   max_sends;
  } cfg_t;

  // Up to two results caused by one input transaction.
  typedef struct packed {
    logic    first_valid;
    logic    second_valid;
    result_t first;
    result_t second;
  } outcome_t;

endpackage

FILE: rtl/stop_and_wait_arq_sender.sv
// ----------------------------------------------------------------------------
// Stop-and-wait ARQ sender
// Turns chunk, ack, tick and end-of-data events into packet send requests,
// completion reports, abort notices and end markers for a stop-and-wait link.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Carries
//  s_axis    in         tvalid / tready           events: kind, ack_seq, chunk_length
//  m_axis    out        tvalid / tready / tlast   results: action, seq, length, attempt
//  APB       in         psel / penable / pready   timeout_ticks, late_ack_ticks, max_sends
//
//  One input transaction is taken every cycle while results keep draining. Its
//  results appear on m_axis in the next cycle, from a two-entry output buffer.
//  An event that ends in an abort yields two results (abort, then end marker);
//  the second entry of the buffer then holds s_axis_tready low until the abort
//  has been taken, and so for as long as m_axis stalls on the abort.
//  While a result waits in the first entry and the second is free, s_axis_tready
//  follows m_axis_tready, so a stall on m_axis blocks s_axis in the same cycle.
//  Reset is asynchronous and active low; no clearing pass follows it.
//
module stop_and_wait_arq_sender #(
  parameter int unsigned SEQ_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] ack_seq, [28:16] chunk_length, rest zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [15:0] seq_out, [28:16] length_out, [32:29] attempt
  output logic [1:0]  m_axis_tuser,   // [1:0] action
  output logic        m_axis_tlast,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import swarq_pkg::*;

  cfg_t     cfg_q;
  outcome_t outcome;
  logic     in_accept;
  logic     out_pop;
  logic     cfg_write;
  reg_e     reg_sel;

  result_t  slot0_q, slot1_q;
  logic     slot0_valid_q, slot1_valid_q;

  // Configuration registers. Writes are only expected while the sender is idle.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks  <= TIMEOUT_RST;
      cfg_q.late_ack_ticks <= LATE_ACK_RST;
      cfg_q.max_sends      <= MAX_SENDS_RST;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_TIMEOUT:   cfg_q.timeout_ticks  <= pwdata[TIMER_W-1:0];
        REG_LATE_ACK:  cfg_q.late_ack_ticks <= pwdata[TIMER_W-1:0];
        REG_MAX_SENDS: cfg_q.max_sends      <= pwdata[ATT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TIMEOUT:   prdata = 32'(cfg_q.timeout_ticks);
      REG_LATE_ACK:  prdata = 32'(cfg_q.late_ack_ticks);
      REG_MAX_SENDS: prdata = 32'(cfg_q.max_sends);
      default:       prdata = '0;
    endcase
  end

  // An input transaction is taken only when the buffer can absorb two results:
  // the second slot must be free and the first must be free or draining.
  assign s_axis_tready = !slot1_valid_q && (!slot0_valid_q || m_axis_tready);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_pop       = slot0_valid_q && m_axis_tready;

  swarq_fsm #(
    .SEQ_BITS(SEQ_BITS)
  ) u_fsm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .kind_i        (kind_e'(s_axis_tuser)),
    .ack_seq_i     (s_axis_tdata[15:0]),
    .chunk_length_i(s_axis_tdata[28:16]),
    .cfg_i         (cfg_q),
    .outcome_o     (outcome)
  );

  // Output buffer. Slot 0 drives m_axis; slot 1 holds the end marker that
  // follows an abort until slot 0 has been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot0_valid_q <= 1'b0;
      slot1_valid_q <= 1'b0;
    end else if (outcome.first_valid) begin
      slot0_valid_q <= 1'b1;
      slot1_valid_q <= outcome.second_valid;
    end else if (out_pop) begin
      slot0_valid_q <= slot1_valid_q;
      slot1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (outcome.first_valid) begin
      slot0_q <= outcome.first;
      slot1_q <= outcome.second;
    end else if (out_pop) begin
      slot0_q <= slot1_q;
    end
  end

  assign m_axis_tvalid = slot0_valid_q;
  assign m_axis_tdata  = {7'b0, slot0_q.attempt, slot0_q.length, slot0_q.seq};
  assign m_axis_tuser  = slot0_q.action;
  assign m_axis_tlast  = slot0_q.last;

endmodule

FILE: rtl/swarq_fsm.sv
// ----------------------------------------------------------------------------
// Stop-and-wait ARQ sender state machine
// Holds the protocol state and works out the results of one transaction.
// ----------------------------------------------------------------------------
module swarq_fsm #(
  parameter int unsigned SEQ_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  swarq_pkg::kind_e              kind_i,
  input  logic [swarq_pkg::SEQ_W-1:0]   ack_seq_i,
  input  logic [swarq_pkg::LEN_W-1:0]   chunk_length_i,
  input  swarq_pkg::cfg_t               cfg_i,
  output swarq_pkg::outcome_t           outcome_o
);
  import swarq_pkg::*;

  mode_e                mode_q, mode_d;
  logic [SEQ_BITS-1:0]  next_seq_q, next_seq_d;
  logic [LEN_W-1:0]     held_length_q, held_length_d;
  logic [ATT_W-1:0]     send_count_q, send_count_d;
  logic [TIMER_W-1:0]   wait_timer_q, wait_timer_d;

  logic                 busy;
  logic                 fail;
  logic                 ack_match;
  logic [LEN_W-1:0]     len_sat;
  logic [SEQ_BITS+SEQ_W-1:0] seq_ext;
  logic [SEQ_BITS+SEQ_W-1:0] ack_ext;
  logic [SEQ_W-1:0]     seq_cur;
  logic [ATT_W-1:0]     count_inc;

  // The sequence counter may be wider or narrower than the packet field.
  assign seq_ext   = {{SEQ_W{1'b0}}, next_seq_q};
  assign ack_ext   = {{SEQ_BITS{1'b0}}, ack_seq_i};
  assign seq_cur   = seq_ext[SEQ_W-1:0];
  assign ack_match = (ack_ext == seq_ext);
  assign busy      = (mode_q == MODE_WAIT) || (mode_q == MODE_LATE);
  assign len_sat   = (chunk_length_i > MAX_CHUNK) ? MAX_CHUNK : chunk_length_i;
  assign count_inc = send_count_q + 1'b1;

  always_comb begin
    mode_d        = mode_q;
    next_seq_d    = next_seq_q;
    held_length_d = held_length_q;
    send_count_d  = send_count_q;
    wait_timer_d  = wait_timer_q;
    fail          = 1'b0;
    outcome_o     = '0;

    if (!busy) begin
      mode_d = MODE_IDLE;
    end

    unique case (kind_i)
      KIND_CHUNK: begin
        if (!busy) begin
          held_length_d = len_sat;
          send_count_d  = ATT_W'(1);
          wait_timer_d  = cfg_i.timeout_ticks;
          mode_d        = MODE_WAIT;
          outcome_o.first_valid = 1'b1;
          outcome_o.first = '{ACT_DATA, seq_cur, len_sat, ATT_W'(1), 1'b1};
        end
      end
      KIND_ACK: begin
        if (busy) begin
          if (ack_match) begin
            outcome_o.first_valid = 1'b1;
            outcome_o.first = '{ACT_ACKED, seq_cur, held_length_q, send_count_q, 1'b1};
            next_seq_d   = next_seq_q + 1'b1;
            mode_d       = MODE_IDLE;
            wait_timer_d = '0;
          end else if (mode_q == MODE_WAIT) begin
            mode_d       = MODE_LATE;
            wait_timer_d = cfg_i.late_ack_ticks;
          end else begin
            fail = 1'b1;
          end
        end
      end
      KIND_TICK: begin
        if (busy) begin
          if (wait_timer_q <= TIMER_W'(1)) begin
            wait_timer_d = '0;
            fail         = 1'b1;
          end else begin
            wait_timer_d = wait_timer_q - 1'b1;
          end
        end
      end
      KIND_END: begin
        outcome_o.first_valid = 1'b1;
        outcome_o.first = '{ACT_END, seq_cur, '0, '0, 1'b1};
        next_seq_d    = SEQ_BITS'(1);
        mode_d        = MODE_IDLE;
        held_length_d = '0;
        send_count_d  = '0;
        wait_timer_d  = '0;
      end
      default: ;
    endcase

    // A failed wait either resends the held chunk or gives up on it.
    if (fail) begin
      outcome_o.first_valid = 1'b1;
      if (send_count_q >= cfg_i.max_sends) begin
        outcome_o.first = '{ACT_ABORT, seq_cur, held_length_q, send_count_q, 1'b0};
        outcome_o.second_valid = 1'b1;
        outcome_o.second = '{ACT_END, seq_cur, '0, '0, 1'b1};
        next_seq_d    = SEQ_BITS'(1);
        mode_d        = MODE_IDLE;
        held_length_d = '0;
        send_count_d  = '0;
        wait_timer_d  = '0;
      end else begin
        send_count_d = count_inc;
        wait_timer_d = cfg_i.timeout_ticks;
        mode_d       = MODE_WAIT;
        outcome_o.first = '{ACT_DATA, seq_cur, held_length_q, count_inc, 1'b1};
      end
    end

    if (!accept_i) begin
      outcome_o = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_IDLE;
      next_seq_q    <= SEQ_BITS'(1);
      held_length_q <= '0;
      send_count_q  <= '0;
      wait_timer_q  <= '0;
    end else if (accept_i) begin
      mode_q        <= mode_d;
      next_seq_q    <= next_seq_d;
      held_length_q <= held_length_d;
      send_count_q  <= send_count_d;
      wait_timer_q  <= wait_timer_d;
    end
  end

endmodule

FILE: rtl/swarq_checker.sv
// ----------------------------------------------------------------------------
// Stop-and-wait ARQ sender checker
// Watches the sender's ports and flags result sequences that cannot occur.
// ----------------------------------------------------------------------------
module swarq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import swarq_pkg::*;

  // A stalled result keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // An abort is never the final result of its transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ACT_ABORT) |-> !m_axis_tlast)
    else $error("abort marked as last");

  // The end marker follows an abort in the very next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && (m_axis_tuser == ACT_ABORT)
      |=> m_axis_tvalid && (m_axis_tuser == ACT_END) && m_axis_tlast)
    else $error("abort not followed by end marker");

  // The end marker carries no length and no attempt number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ACT_END) |-> (m_axis_tdata[32:16] == '0))
    else $error("end marker with length or attempt");

  // Every data send carries a nonzero attempt number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ACT_DATA) |-> (m_axis_tdata[32:29] != '0))
    else $error("data send with attempt zero");

endmodule

bind stop_and_wait_arq_sender swarq_checker u_swarq_checker (.*);
